[sv/page_table_builder_assert.svh]
// Assertion macros shared by the page table builder checkers.
// Both macros expect clk and arst_n to be visible where they are used.
`ifndef PAGE_TABLE_BUILDER_ASSERT_SVH
`define PAGE_TABLE_BUILDER_ASSERT_SVH

// Same-cycle implication.
`define PTB_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("ptb_checker: same-cycle property failed");

// Next-cycle implication.
`define PTB_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ptb_checker: next-cycle property failed");

`endif

[sv/ptb_pkg.sv]
// ----------------------------------------------------------------------------
// Page table builder package
// Pool geometry, command and status codes, the microcode word and the
// microprogram of the walk sequencer, and small address helpers.
// ----------------------------------------------------------------------------
package ptb_pkg;

	localparam int POOL_PAGES = 64;
	localparam int IDX_W      = 9;
	localparam int ENTRIES    = 512;
	localparam int PAGE_W     = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
	localparam int MEM_DEPTH  = POOL_PAGES * ENTRIES;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int NFP_W      = $clog2(POOL_PAGES + 1);
	localparam int VA_W       = 48;
	localparam int PA_W       = 52;
	localparam int PFN_W      = 40;
	localparam int ENTRY_W    = 64;
	localparam int TP_W       = 6;
	localparam int CMP_W      = 13;

	localparam logic [ENTRY_W-1:0] LINK_FLAGS = 64'h3;
	localparam logic [ENTRY_W-1:0] BIG_FLAGS  = 64'h83;

	typedef enum logic [1:0] {
		CMD_MAP4K = 2'd0,
		CMD_MAP2M = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_OUTSIDE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		UOP_NONE,
		UOP_LOAD,
		UOP_ROOT,
		UOP_WALK_RD,
		UOP_LATCH,
		UOP_ALLOC,
		UOP_CHECK,
		UOP_LEAF,
		UOP_ITEM_RD,
		UOP_ITEM_VAL,
		UOP_DONE
	} uop_t;

	typedef enum logic [3:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_START,
		COND_IS_READ,
		COND_IS_NOP,
		COND_NONZERO,
		COND_FULL,
		COND_OUTSIDE,
		COND_MORE,
		COND_TP_OUT
	} cond_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP_READ,
		S_DISP_NOP,
		S_ROOT,
		S_WALK_RD,
		S_LATCH,
		S_ALLOC,
		S_CHECK,
		S_NEXT,
		S_LEAF,
		S_ITEM_RD,
		S_ITEM_VAL,
		S_FIN
	} step_t;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		step_t target;
	} ucw_t;

	typedef struct packed {
		logic start;
		logic is_read;
		logic is_nop;
		logic nonzero;
		logic full;
		logic outside;
		logic more;
		logic tp_out;
	} flags_t;

	// A step that does not jump falls through to the next one.
	function automatic ucw_t ucode(input step_t s);
		ucw_t w;
		case (s)
			S_IDLE:      w = '{op: UOP_LOAD,     cond: COND_NO_START, target: S_IDLE};
			S_DISP_READ: w = '{op: UOP_NONE,     cond: COND_IS_READ,  target: S_ITEM_RD};
			S_DISP_NOP:  w = '{op: UOP_NONE,     cond: COND_IS_NOP,   target: S_FIN};
			S_ROOT:      w = '{op: UOP_ROOT,     cond: COND_NEVER,    target: S_IDLE};
			S_WALK_RD:   w = '{op: UOP_WALK_RD,  cond: COND_NEVER,    target: S_IDLE};
			S_LATCH:     w = '{op: UOP_LATCH,    cond: COND_NONZERO,  target: S_CHECK};
			S_ALLOC:     w = '{op: UOP_ALLOC,    cond: COND_FULL,     target: S_FIN};
			S_CHECK:     w = '{op: UOP_CHECK,    cond: COND_OUTSIDE,  target: S_FIN};
			S_NEXT:      w = '{op: UOP_NONE,     cond: COND_MORE,     target: S_WALK_RD};
			S_LEAF:      w = '{op: UOP_LEAF,     cond: COND_ALWAYS,   target: S_FIN};
			S_ITEM_RD:   w = '{op: UOP_ITEM_RD,  cond: COND_TP_OUT,   target: S_FIN};
			S_ITEM_VAL:  w = '{op: UOP_ITEM_VAL, cond: COND_NEVER,    target: S_IDLE};
			S_FIN:       w = '{op: UOP_DONE,     cond: COND_ALWAYS,   target: S_IDLE};
			default:     w = '{op: UOP_NONE,     cond: COND_ALWAYS,   target: S_IDLE};
		endcase
		return w;
	endfunction

	// Table index used at walk level lvl. A 2 MiB map always starts at root
	// entry zero and places its leaf at level two.
	function automatic logic [IDX_W-1:0] walk_index(input logic is_2m,
			input logic [1:0] lvl, input logic [VA_W-1:0] va);
		logic [IDX_W-1:0] idx;
		case (lvl)
			2'd0:    idx = is_2m ? '0 : va[47:39];
			2'd1:    idx = va[38:30];
			2'd2:    idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [PAGE_W-1:0] page,
			input logic [IDX_W-1:0] idx);
		return ADDR_W'({page, idx});
	endfunction

endpackage

[sv/ptb_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/ptb_seq.sv]
// ----------------------------------------------------------------------------
// Page table builder sequencer
// Step counter over the microprogram ROM with conditional jumps.
// ----------------------------------------------------------------------------
module ptb_seq
	import ptb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output ucw_t   cw,
	output logic   idle
);

	step_t pc_q;
	step_t pc_d;
	logic  take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_comb begin
		cw = ucode(pc_q);
		case (cw.cond)
			COND_NEVER:    take = 1'b0;
			COND_ALWAYS:   take = 1'b1;
			COND_NO_START: take = !flags.start;
			COND_IS_READ:  take = flags.is_read;
			COND_IS_NOP:   take = flags.is_nop;
			COND_NONZERO:  take = flags.nonzero;
			COND_FULL:     take = flags.full;
			COND_OUTSIDE:  take = flags.outside;
			COND_MORE:     take = flags.more;
			COND_TP_OUT:   take = flags.tp_out;
			default:       take = 1'b1;
		endcase
		pc_d = take ? cw.target : step_t'(pc_q + 4'd1);
		idle = (pc_q == S_IDLE);
	end

endmodule

[sv/page_table_builder.sv]
// ----------------------------------------------------------------------------
// Four-level page table builder
// Builds x86-64 style page tables in a pool of table pages held in one RAM.
//
//   channel  | ports                                         | handshake
//   ---------+-----------------------------------------------+------------------
//   command  | cmd virt_addr phys_addr table_page entry_index | start, busy
//   result   | status entry_value pages_used                  | done, one cycle
//   config   | cfg_wdata (pool_base)                          | cfg_we
//
// One beat at a time: a command is taken when start is high and busy is low,
// and its result shows with done at the end of the command. A read runs the
// item read and item value steps; a map walks the levels, with an allocation
// step for each table page allocated. The walk is bound by the table RAM,
// one registered read per level. After reset busy stays high for a clearing
// pass over all 32768 RAM entries, one entry per cycle. The result beat cannot be held off.
// ----------------------------------------------------------------------------
module page_table_builder
	import ptb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          cmd,
	input  logic [VA_W-1:0]     virt_addr,
	input  logic [PA_W-1:0]     phys_addr,
	input  logic [TP_W-1:0]     table_page,
	input  logic [IDX_W-1:0]    entry_index,
	output logic                done,
	output logic [1:0]          status,
	output logic [ENTRY_W-1:0]  entry_value,
	output logic [6:0]          pages_used,
	input  logic                cfg_we,
	input  logic [PA_W-1:0]     cfg_wdata
);

	ucw_t                 cw;
	flags_t               flags;
	logic                 idle;

	logic                 clearing_q;
	logic [ADDR_W-1:0]    clr_addr_q;
	logic [PFN_W-1:0]     pool_pfn_q;
	logic [NFP_W-1:0]     nfp_q;

	cmd_t                 cmd_q;
	logic [VA_W-1:0]      va_q;
	logic [PA_W-1:0]      pa_q;
	logic [TP_W-1:0]      tp_q;
	logic [IDX_W-1:0]     ei_q;
	logic [1:0]           lvl_q;
	logic [PAGE_W-1:0]    page_q;
	logic [PFN_W-1:0]     link_q;
	status_t              status_q;
	logic [ENTRY_W-1:0]   value_q;

	logic                 is_2m;
	logic [1:0]           levels;
	logic [IDX_W-1:0]     cur_idx;
	logic [ADDR_W-1:0]    walk_slot;
	logic [ADDR_W-1:0]    item_slot;
	logic [PFN_W-1:0]     link_pfn;
	logic [PFN_W-1:0]     diff;
	logic                 outside;
	logic                 full;
	logic                 tp_out;
	logic [ENTRY_W-1:0]   leaf_val;

	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_waddr;
	logic [ENTRY_W-1:0]   mem_wdata;
	logic [ADDR_W-1:0]    mem_raddr;
	logic [ENTRY_W-1:0]   rd_data;

	ptb_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.cw     (cw),
		.idle   (idle)
	);

	ptb_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MEM_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	always_comb begin
		is_2m     = (cmd_q == CMD_MAP2M);
		levels    = is_2m ? 2'd2 : 2'd3;
		cur_idx   = walk_index(is_2m, lvl_q, va_q);
		walk_slot = slot_addr(page_q, cur_idx);
		item_slot = slot_addr(PAGE_W'(tp_q), ei_q);
		link_pfn  = pool_pfn_q + PFN_W'(nfp_q);
		diff      = link_q - pool_pfn_q;
		outside   = (diff >= PFN_W'(POOL_PAGES));
		full      = (nfp_q >= NFP_W'(POOL_PAGES));
		tp_out    = (CMP_W'(tp_q) >= CMP_W'(POOL_PAGES));
		if (is_2m) begin
			leaf_val = {25'd0, va_q[38:21], 21'd0} | BIG_FLAGS;
		end else begin
			leaf_val = {12'd0, pa_q} | LINK_FLAGS;
		end

		flags.start   = start && !clearing_q;
		flags.is_read = (cmd_q == CMD_READ);
		flags.is_nop  = (cmd_q == CMD_NOP);
		flags.nonzero = (rd_data != '0);
		flags.full    = full;
		flags.outside = outside;
		flags.more    = (lvl_q != levels);
		flags.tp_out  = tp_out;

		mem_we    = 1'b0;
		mem_waddr = walk_slot;
		mem_wdata = leaf_val;
		if (clearing_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			case (cw.op)
				UOP_ALLOC: begin
					mem_we    = !full;
					mem_wdata = {12'd0, link_pfn, 12'd0} | LINK_FLAGS;
				end
				UOP_LEAF: begin
					mem_we = 1'b1;
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
		mem_raddr = (cw.op == UOP_ITEM_RD) ? item_slot : walk_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			pool_pfn_q <= '0;
			nfp_q      <= '0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (cfg_we) begin
				pool_pfn_q <= cfg_wdata[PA_W-1:12];
			end
			if (cw.op == UOP_ROOT && nfp_q == '0) begin
				nfp_q <= NFP_W'(1);
			end else if (cw.op == UOP_ALLOC && !full) begin
				nfp_q <= nfp_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cw.op)
			UOP_LOAD: begin
				if (flags.start) begin
					cmd_q    <= cmd_t'(cmd);
					va_q     <= virt_addr;
					pa_q     <= phys_addr;
					tp_q     <= table_page;
					ei_q     <= entry_index;
					lvl_q    <= '0;
					page_q   <= '0;
					status_q <= ST_OK;
					value_q  <= '0;
				end
			end
			UOP_LATCH: begin
				link_q <= rd_data[PA_W-1:12];
			end
			UOP_ALLOC: begin
				if (full) begin
					status_q <= ST_FULL;
				end else begin
					link_q <= link_pfn;
				end
			end
			UOP_CHECK: begin
				if (outside) begin
					status_q <= ST_OUTSIDE;
				end else begin
					page_q <= PAGE_W'(diff);
					lvl_q  <= lvl_q + 2'd1;
				end
			end
			UOP_LEAF: begin
				value_q <= leaf_val;
			end
			UOP_ITEM_RD: begin
				if (tp_out) begin
					status_q <= ST_OUTSIDE;
				end
			end
			UOP_ITEM_VAL: begin
				value_q <= rd_data;
			end
			default: begin
			end
		endcase
	end

	assign busy        = !idle || clearing_q;
	assign done        = (cw.op == UOP_DONE);
	assign status      = status_q;
	assign entry_value = value_q;
	assign pages_used  = 7'(nfp_q);

endmodule

[sv/ptb_checker.sv]
// ----------------------------------------------------------------------------
// Page table builder port checker
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`include "page_table_builder_assert.svh"

module ptb_checker
	import ptb_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [1:0]         status,
	input logic [ENTRY_W-1:0] entry_value,
	input logic [6:0]         pages_used
);

	// A result beat only belongs to a command in flight.
	`PTB_ASSERT_NOW(a_done_while_busy, done, busy)
	`PTB_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`PTB_ASSERT_NEXT(a_done_single, done, !done)
	`PTB_ASSERT_NOW(a_error_zero, done && status != ST_OK, entry_value == '0)
	`PTB_ASSERT_NOW(a_pages_grow, 1'b1, pages_used >= $past(pages_used))

endmodule

bind page_table_builder ptb_checker u_ptb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.entry_value (entry_value),
	.pages_used  (pages_used)
);
